// ----- rtl/bounded_deque_with_search_macros.svh -----
// Assertion macros for the bounded deque checker.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define BDQ_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define BDQ_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bdq_pkg.sv -----
// Shared types and codes for the bounded deque with search.
`default_nettype none

package bdq_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DONE
	} st_t;

	localparam logic [3:0] CMD_INS_HEAD  = 4'd0;
	localparam logic [3:0] CMD_INS_TAIL  = 4'd1;
	localparam logic [3:0] CMD_DEL_HEAD  = 4'd2;
	localparam logic [3:0] CMD_DEL_TAIL  = 4'd3;
	localparam logic [3:0] CMD_DEL_VALUE = 4'd4;
	localparam logic [3:0] CMD_REPLACE   = 4'd5;
	localparam logic [3:0] CMD_SEARCH    = 4'd6;
	localparam logic [3:0] CMD_READ_POS  = 4'd7;
	localparam logic [3:0] CMD_READ_HEAD = 4'd8;
	localparam logic [3:0] CMD_READ_TAIL = 4'd9;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_EMPTY     = 3'd1;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [2:0] STAT_FULL      = 3'd3;
	localparam logic [2:0] STAT_RANGE     = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/bdq_ring_add.sv -----
// Ring slot adder: (base + offset) modulo the capacity.
`default_nettype none

module bdq_ring_add #(
	parameter int CAPACITY = 16
) (
	input  logic [$clog2(CAPACITY)-1:0]   base,
	input  logic [$clog2(CAPACITY+1)-1:0] offs,
	output logic [$clog2(CAPACITY)-1:0]   slot
);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW:0] sum;
	logic [CW:0] wrapped;

	// both operands stay below twice the capacity, one subtract suffices
	assign sum     = (CW + 1)'(base) + (CW + 1)'(offs);
	assign wrapped = (sum >= (CW + 1)'(CAPACITY)) ? sum - (CW + 1)'(CAPACITY) : sum;
	assign slot    = wrapped[IW-1:0];

endmodule

`default_nettype wire

// ----- rtl/bounded_deque_with_search.sv -----
// Top level of the bounded deque with search, delete and replace.
//
// Usage:
//  - Command channel (in_valid/in_stall) carries cmd, value, new_value,
//    all_matches and position. A beat is taken when in_valid is high and
//    in_stall is low. One command is worked on at a time; in_stall is high
//    from the beat until the result has been moved to the output register.
//  - Result channel (out_valid/out_stall) carries status, data and
//    entry_total, one beat per command, in command order.
//  - Inserts, head/tail removal and error cases go straight to the result;
//    reads pass through a read state of the word store first; delete by
//    value, replace and search walk every entry through the single read
//    port of the word store (one entry per cycle), with a compare stage
//    behind the registered read.
//  - A new command is taken while the previous result still waits on
//    out_stall; the block holds the finished result internally if the
//    output register is still occupied.
//  - Reset empties the deque (head slot and count to zero). The word store
//    is not cleared; only words from slots holding entries reach a result.
`default_nettype none

module bounded_deque_with_search
	import bdq_pkg::*;
#(
	parameter int CAPACITY  = 16,
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         cmd,
	input  logic signed [31:0] value,
	input  logic signed [31:0] new_value,
	input  logic               all_matches,
	input  logic [3:0]         position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] data,
	output logic [4:0]         entry_total
);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	st_t state_q, state_d;

	// deque pointers
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;

	// latched command
	logic [3:0]           cmd_q;
	logic                 all_q;
	logic [WORD_BITS-1:0] val_q, nval_q;

	// walk state: read index, compare stage, write index
	logic [CW-1:0] rd_idx_q;
	logic          chk_s1;
	logic [CW-1:0] chk_idx_s1;
	logic [CW-1:0] w_q;
	logic          hit_q;

	// finished result waiting for the output register
	logic [2:0]  res_status_q;
	logic [31:0] res_data_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [31:0] data_q;
	logic [4:0]  total_q;

	// word store
	logic [WORD_BITS-1:0] mem [CAPACITY];
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 mem_we, mem_re;
	logic [IW-1:0]        mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata;

	// slot adders: A for command/read addresses, B for walk writes
	logic [CW-1:0] a_offs, b_offs;
	logic [IW-1:0] a_slot, b_slot;

	logic signed [63:0]          value64, nvalue64;
	logic [WORD_BITS-1:0]        val_in, nval_in;
	logic signed [WORD_BITS-1:0] rd_word;
	logic signed [63:0]          rd_word64;

	logic full, empty, pos_bad;
	logic rd_go, eq, take, last, hit_fin, load_out;

	// words live in their low WORD_BITS bits
	assign value64   = 64'(value);
	assign nvalue64  = 64'(new_value);
	assign val_in    = value64[WORD_BITS-1:0];
	assign nval_in   = nvalue64[WORD_BITS-1:0];
	assign rd_word   = rd_data_q;
	assign rd_word64 = 64'(rd_word);

	assign full    = (count_q == CW'(CAPACITY));
	assign empty   = (count_q == '0);
	assign pos_bad = (32'(position) >= 32'(count_q));

	// walk compare stage
	assign rd_go   = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign eq      = (rd_data_q == val_q);
	assign take    = eq && ((cmd_q == CMD_SEARCH) || all_q || !hit_q);
	assign last    = chk_s1 && (chk_idx_s1 == count_q - CW'(1));
	assign hit_fin = hit_q || take;

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		a_offs = rd_idx_q;
		if (state_q == ST_IDLE) begin
			case (cmd)
				CMD_INS_HEAD:  a_offs = CW'(CAPACITY - 1);
				CMD_INS_TAIL:  a_offs = count_q;
				CMD_DEL_HEAD:  a_offs = CW'(1);
				CMD_READ_POS:  a_offs = CW'(position);
				CMD_READ_TAIL: a_offs = count_q - CW'(1);
				default:       a_offs = '0;
			endcase
		end
	end

	// delete packs toward the head at w_q; replace rewrites in place
	assign b_offs = (cmd_q == CMD_DEL_VALUE) ? w_q : chk_idx_s1;

	bdq_ring_add #(.CAPACITY(CAPACITY)) u_add_a (
		.base (head_q),
		.offs (a_offs),
		.slot (a_slot)
	);

	bdq_ring_add #(.CAPACITY(CAPACITY)) u_add_b (
		.base (head_q),
		.offs (b_offs),
		.slot (b_slot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (cmd) inside
						CMD_DEL_VALUE, CMD_REPLACE, CMD_SEARCH:
							state_d = empty ? ST_DONE : ST_SCAN;
						CMD_READ_HEAD, CMD_READ_TAIL:
							state_d = empty ? ST_DONE : ST_READ;
						CMD_READ_POS:
							state_d = pos_bad ? ST_DONE : ST_READ;
						default:
							state_d = ST_DONE;
					endcase
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_SCAN: if (last) state_d = ST_DONE;
			ST_DONE: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and store port control
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = a_slot;
		mem_raddr = a_slot;
		mem_wdata = val_in;
		unique case (state_q)
			ST_IDLE: begin
				mem_we = in_valid && !full &&
					((cmd == CMD_INS_HEAD) || (cmd == CMD_INS_TAIL));
				mem_re = in_valid && ((cmd == CMD_READ_POS) ||
					(cmd == CMD_READ_HEAD) || (cmd == CMD_READ_TAIL));
			end
			ST_SCAN: begin
				mem_re    = rd_go;
				mem_waddr = b_slot;
				mem_wdata = (cmd_q == CMD_REPLACE) ? nval_q : rd_data_q;
				mem_we    = chk_s1 &&
					(((cmd_q == CMD_REPLACE) && take) ||
					 ((cmd_q == CMD_DEL_VALUE) && !take));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_IDLE) && in_valid) begin
				case (cmd)
					CMD_INS_HEAD: if (!full) begin
						head_q  <= a_slot;
						count_q <= count_q + CW'(1);
					end
					CMD_INS_TAIL: if (!full) count_q <= count_q + CW'(1);
					CMD_DEL_HEAD: if (!empty) begin
						head_q  <= a_slot;
						count_q <= count_q - CW'(1);
					end
					CMD_DEL_TAIL: if (!empty) count_q <= count_q - CW'(1);
					default: begin
					end
				endcase
			end
			if ((state_q == ST_SCAN) && last && (cmd_q == CMD_DEL_VALUE) && hit_fin)
				count_q <= w_q + CW'(!take);
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			cmd_q        <= cmd;
			all_q        <= all_matches;
			val_q        <= val_in;
			nval_q       <= nval_in;
			rd_idx_q     <= '0;
			chk_s1       <= 1'b0;
			w_q          <= '0;
			hit_q        <= 1'b0;
			res_data_q   <= '0;
			res_status_q <= STAT_OK;
			case (cmd) inside
				CMD_INS_HEAD, CMD_INS_TAIL:
					if (full) res_status_q <= STAT_FULL;
				CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_VALUE, CMD_REPLACE, CMD_SEARCH,
				CMD_READ_HEAD, CMD_READ_TAIL:
					if (empty) res_status_q <= STAT_EMPTY;
				CMD_READ_POS:
					if (pos_bad) res_status_q <= STAT_RANGE;
				default: begin
				end
			endcase
		end
		if (state_q == ST_READ) res_data_q <= rd_word64[31:0];
		if (state_q == ST_SCAN) begin
			rd_idx_q   <= rd_idx_q + CW'(rd_go);
			chk_s1     <= rd_go;
			chk_idx_s1 <= rd_idx_q;
			if (chk_s1) begin
				if (take) hit_q <= 1'b1;
				if ((cmd_q == CMD_DEL_VALUE) && !take) w_q <= w_q + CW'(1);
				if (last && !hit_fin) res_status_q <= STAT_NOT_FOUND;
			end
		end
		if (load_out) begin
			status_q <= res_status_q;
			data_q   <= res_data_q;
			total_q  <= 5'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign data        = data_q;
	assign entry_total = total_q;

endmodule

`default_nettype wire

// ----- rtl/bdq_checker.sv -----
// Port-level checker for the bounded deque, bound to the top level.
`default_nettype none

`include "bounded_deque_with_search_macros.svh"

module bdq_checker #(
	parameter int CAPACITY = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  status,
	input wire logic [31:0] data,
	input wire logic [4:0]  entry_total
);

	`BDQ_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(data) && $stable(entry_total), "stalled result beat changed")
	`BDQ_NEXT(a_one_cmd, in_valid && !in_stall, in_stall, "second command taken while one is in flight")
	`BDQ_HOLDS(a_status_code, !out_valid || (status <= 3'd4), "result status code out of range")
	`BDQ_HOLDS(a_total_cap, !out_valid || (32'(entry_total) <= CAPACITY), "entry count beyond capacity")

endmodule

bind bounded_deque_with_search bdq_checker #(.CAPACITY(CAPACITY)) u_bdq_checker (.*);

`default_nettype wire
